FILE: rtl/serial_bank_switch_mapper_unit_macros.svh
// Assertion macros for the serial bank switch mapper.
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SBSM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SBSM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/sbsm_pkg.sv
// Shared types and constants of the serial bank switch mapper.
`default_nettype none

package sbsm_pkg;

    localparam int RAM_DEPTH_DEF = 8192;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 8;
    localparam int MAP_W         = 18;

    // Access kinds
    typedef enum logic [1:0] {
        OP_CPU_RD = 2'd0,
        OP_CPU_WR = 2'd1,
        OP_PPU_RD = 2'd2,
        OP_PPU_WR = 2'd3
    } op_t;

    // Serial load targets, address bits 14:13
    typedef enum logic [1:0] {
        TGT_CONTROL = 2'd0,
        TGT_CHR_LOW = 2'd1,
        TGT_CHR_HIGH = 2'd2,
        TGT_PRG     = 2'd3
    } target_t;

    // Configuration register indexes
    localparam logic REG_PRG_COUNT = 1'b0;
    localparam logic REG_CHR_COUNT = 1'b1;

    localparam logic [4:0] CTRL_RESET = 5'h1C;
    localparam logic [4:0] CTRL_LOCK  = 5'h0C;
    localparam logic [1:0] MIRROR_RESET = 2'd3;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd16;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
    } item_t;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] chr_8k;
        logic [2:0] prg_32k;
        logic [3:0] prg_low;
        logic [3:0] prg_high;
        logic [1:0] mirror;
    } banks_t;

    typedef struct packed {
        logic              handled;
        logic              to_ram;
        logic [MAP_W-1:0]  rom_offset;
        logic [DATA_W-1:0] read_data;
        logic [1:0]        mirror_mode;
    } result_t;

    // Work RAM window 0x6000-0x7FFF
    function automatic logic in_work_ram(input logic [ADDR_W-1:0] a);
        return a[15:13] == 3'b011;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/serial_bank_switch_mapper_unit.sv
// Serial bank switch mapper: top level with handshake, work RAM and config port.
//
// Usage: each input word on s_* is one bus access. s_tuser carries the access
// kind (CPU read, CPU write, PPU read, PPU write), s_tdata the address and the
// byte written. Every accepted word gives exactly one result word on m_*:
// claim and work RAM flags in m_tuser, translated ROM offset, work RAM byte
// and mirroring mode in m_tdata. Bank counts are set over the APB port while
// the block is idle; address 0 is the program bank count, 4 the pattern count.
// From acceptance, the work RAM read and the input register come first, then
// translation into the result register and m_tvalid. One word is accepted
// every cycle while the receiver keeps up; the single work RAM port is used
// at most once per access, only for CPU accesses in the work RAM window. After
// reset the work RAM is swept to zero, one byte a cycle, over RAM_DEPTH bytes
// (8192 by default); s_tready stays low until it is done, while configuration
// writes are taken as usual. On a receiver stall the result and input registers
// hold their words; s_tready drops once both are full; none is lost or repeated.
`default_nettype none

`include "serial_bank_switch_mapper_unit_macros.svh"

module serial_bank_switch_mapper_unit
    import sbsm_pkg::*;
#(
    parameter int RAM_DEPTH = RAM_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Access stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // addr[15:0], write_data[23:16]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    // Result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // rom_offset[17:0], read_data[25:18],
                                        // mirror_mode[27:26], zero[31:28]
    output logic [1:0]       m_tuser    // handled[0], to_ram[1]
);

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic [4:0]  prg_count_reg;
    logic [5:0]  chr_count_reg;
    logic        clr_active_reg;
    logic [RAM_AW-1:0] clr_addr_reg;
    logic        s1_valid_reg, s1_valid_next;
    item_t       s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    item_t       in_item;
    logic        accept, advance, cfg_wr;
    logic        ram_en, ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    banks_t      banks;
    logic [1:0]  mirror_next;
    result_t     res;

    assign in_item = '{op: op_t'(s_tuser), addr: s_tdata[15:0], wdata: s_tdata[23:16]};
    assign accept  = s_tvalid && s_tready;
    assign advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!s1_valid_reg || advance);

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CHR_COUNT) ? {26'd0, chr_count_reg}
                                                : {27'd0, prg_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= PRG_COUNT_RESET;
            chr_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PRG_COUNT)
                prg_count_reg <= pwdata[4:0];
            else
                chr_count_reg <= pwdata[5:0];
        end
    end

    // Sweep the work RAM to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + RAM_AW'(1);
            if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // Work RAM port: sweep, or the access of the word being accepted
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_en    = accept && in_work_ram(in_item.addr)
                        && (in_item.op == OP_CPU_RD || in_item.op == OP_CPU_WR);
            ram_we    = in_item.op == OP_CPU_WR;
            ram_addr  = in_item.addr[RAM_AW-1:0];
            ram_wdata = in_item.wdata;
        end
    end

    sbsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sbsm_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .upd            (advance),
        .item           (s1_item_reg),
        .prg_bank_count (prg_count_reg),
        .banks          (banks),
        .mirror_next    (mirror_next)
    );

    sbsm_xlate u_xlate (
        .item           (s1_item_reg),
        .banks          (banks),
        .chr_bank_count (chr_count_reg),
        .ram_rdata      (ram_rdata),
        .mirror_next    (mirror_next),
        .res            (res)
    );

    // Advance the two-word pipeline
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= in_item;
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.mirror_mode, out_res_reg.read_data,
                       out_res_reg.rom_offset};
    assign m_tuser  = {out_res_reg.to_ram, out_res_reg.handled};

    // Checks
    `SBSM_ASSERT_NOW(a_no_accept_in_sweep, clr_active_reg, !s_tready)
    `SBSM_ASSERT_NEXT(a_stalled_word_kept, s1_valid_reg && out_valid_reg && !m_tready,
                      s1_valid_reg)
    `SBSM_ASSERT_NOW(a_ram_hit_claimed, m_tvalid && m_tuser[1], m_tuser[0])
    `SBSM_ASSERT_NEXT(a_result_follows, advance, m_tvalid)

endmodule

`default_nettype wire

FILE: rtl/sbsm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module sbsm_ram
    import sbsm_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = RAM_DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbsm_regs.sv
// Serial loader and bank registers.
`default_nettype none

module sbsm_regs
    import sbsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       upd,
    input  wire item_t      item,
    input  wire logic [4:0] prg_bank_count,
    output banks_t          banks,
    output logic [1:0]      mirror_next
);

    banks_t     banks_reg, banks_next;
    logic [4:0] shift_reg, shift_next;
    logic [2:0] count_reg, count_next;
    logic [4:0] v;
    logic [2:0] cnt_inc;
    logic [3:0] last_bank;

    assign last_bank = 4'(prg_bank_count - 5'd1);
    assign v         = {item.wdata[0], shift_reg[4:1]};
    assign cnt_inc   = count_reg + 3'd1;

    // Work out the register file after one serial write
    always_comb
    begin
        banks_next = banks_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (upd && item.op == OP_CPU_WR && item.addr[15])
        begin
            if (item.wdata[7])
            begin
                shift_next = '0;
                count_next = '0;
                banks_next.control = banks_reg.control | CTRL_LOCK;
            end
            else if (cnt_inc == 3'd5)
            begin
                shift_next = '0;
                count_next = '0;
                case (target_t'(item.addr[14:13]))
                    TGT_CONTROL:
                    begin
                        banks_next.control = v;
                        banks_next.mirror  = v[1:0];
                    end
                    TGT_CHR_LOW:
                    begin
                        if (banks_reg.control[4])
                            banks_next.chr_low = v;
                        else
                            banks_next.chr_8k = {v[4:1], 1'b0};
                    end
                    TGT_CHR_HIGH:
                    begin
                        if (banks_reg.control[4])
                            banks_next.chr_high = v;
                    end
                    TGT_PRG:
                    begin
                        case (banks_reg.control[3:2])
                            2'd2:
                            begin
                                banks_next.prg_low  = '0;
                                banks_next.prg_high = v[3:0];
                            end
                            2'd3:
                            begin
                                banks_next.prg_low  = v[3:0];
                                banks_next.prg_high = last_bank;
                            end
                            default:
                                banks_next.prg_32k = v[3:1];
                        endcase
                    end
                    default:
                        banks_next = banks_reg;
                endcase
            end
            else
            begin
                shift_next = v;
                count_next = cnt_inc;
            end
        end
    end

    // Hold state between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_reg <= '{control: CTRL_RESET, chr_low: '0, chr_high: '0, chr_8k: '0,
                           prg_32k: '0, prg_low: '0,
                           prg_high: 4'(PRG_COUNT_RESET - 5'd1), mirror: MIRROR_RESET};
            shift_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            banks_reg <= banks_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

    assign banks       = banks_reg;
    assign mirror_next = banks_next.mirror;

endmodule

`default_nettype wire

FILE: rtl/sbsm_xlate.sv
// Address translation and result formation for one access.
`default_nettype none

module sbsm_xlate
    import sbsm_pkg::*;
(
    input  wire item_t             item,
    input  wire banks_t            banks,
    input  wire logic [5:0]        chr_bank_count,
    input  wire logic [DATA_W-1:0] ram_rdata,
    input  wire logic [1:0]        mirror_next,
    output result_t                res
);

    logic ram_hit;

    assign ram_hit = in_work_ram(item.addr);

    // Decode the access and pick the bank
    always_comb
    begin
        res             = '0;
        res.mirror_mode = mirror_next;
        case (item.op)
            OP_CPU_RD:
            begin
                if (ram_hit)
                begin
                    res.handled   = 1'b1;
                    res.to_ram    = 1'b1;
                    res.read_data = ram_rdata;
                end
                else if (item.addr[15])
                begin
                    res.handled = 1'b1;
                    if (banks.control[3])
                        res.rom_offset = {(item.addr[14] ? banks.prg_high : banks.prg_low),
                                          item.addr[13:0]};
                    else
                        res.rom_offset = {banks.prg_32k, item.addr[14:0]};
                end
            end
            OP_CPU_WR:
            begin
                res.handled = ram_hit;
                res.to_ram  = ram_hit;
            end
            OP_PPU_RD, OP_PPU_WR:
            begin
                if (item.addr[15:13] == 3'd0)
                begin
                    res.handled = 1'b1;
                    if (chr_bank_count == 6'd0)
                        res.rom_offset = MAP_W'(item.addr);
                    else if (item.op == OP_PPU_RD)
                    begin
                        if (banks.control[4])
                            res.rom_offset = MAP_W'({(item.addr[12] ? banks.chr_high
                                                                     : banks.chr_low),
                                                     item.addr[11:0]});
                        else
                            res.rom_offset = {banks.chr_8k, item.addr[12:0]};
                    end
                end
            end
            default:
                res = '0;
        endcase
    end

endmodule

`default_nettype wire
